@@ design/bpq_pkg.sv @@
package bpq_pkg;

    localparam int CAPACITY = 256;
    localparam int LEVELS   = 16;
    localparam int VAL_W    = 32;
    localparam int SLOT_W   = $clog2(CAPACITY);
    localparam int LVL_W    = $clog2(LEVELS);
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int OP_W     = 2;
    localparam int ST_W     = 2;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 32;

    // operation codes; the unused code behaves as a peek
    localparam logic [OP_W-1:0] OP_ENQ  = 2'd0;
    localparam logic [OP_W-1:0] OP_DEQ  = 2'd1;
    localparam logic [OP_W-1:0] OP_PEEK = 2'd2;

    localparam logic [ST_W-1:0] ST_OK    = 2'd0;
    localparam logic [ST_W-1:0] ST_FULL  = 2'd1;
    localparam logic [ST_W-1:0] ST_EMPTY = 2'd2;
    localparam logic [ST_W-1:0] ST_PRIO  = 2'd3;

    localparam logic [CFG_AW-3:0] REG_MAX_PRIO = '0;
    localparam logic [LVL_W-1:0]  MAX_PRIO_RST = 4'd15;

    typedef struct packed {
        logic [SLOT_W-1:0] head;
        logic [SLOT_W-1:0] tail;
    } t_lvl_entry;

    // lowest set bit of the non-empty map
    function automatic logic [LVL_W-1:0] f_lowest(input logic [LEVELS-1:0] map);
        logic [LVL_W-1:0] res;
        res = '0;
        for (int i = LEVELS - 1; i >= 0; i--) begin
            if (map[i]) begin
                res = LVL_W'(i);
            end
        end
        return res;
    endfunction

endpackage

@@ design/bpq_ram.sv @@
module bpq_ram #(
    parameter int WIDTH = bpq_pkg::SLOT_W,
    parameter int DEPTH = bpq_pkg::CAPACITY
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    import bpq_pkg::*;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ design/bpq_cfg.sv @@
module bpq_cfg (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpq_pkg::CFG_AW-1:0]  paddr,
    input  logic [bpq_pkg::CFG_DW-1:0]  pwdata,
    output logic [bpq_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    output logic [bpq_pkg::LVL_W-1:0]   o_max_prio
);
    import bpq_pkg::*;

    logic [LVL_W-1:0] r_max_prio;
    logic             w_sel_max;

    assign w_sel_max = (paddr[CFG_AW-1:2] == REG_MAX_PRIO);
    assign pready    = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_prio <= MAX_PRIO_RST;
        end else if (psel && penable && pwrite && pready && w_sel_max) begin
            r_max_prio <= pwdata[LVL_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (w_sel_max) begin
            prdata = CFG_DW'(r_max_prio);
        end
    end

    assign o_max_prio = r_max_prio;

endmodule

@@ design/bpq_core.sv @@
module bpq_core (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic [bpq_pkg::LVL_W-1:0]  i_max_prio,
    input  logic                       i_in_valid,
    output logic                       o_in_ready,
    input  logic [bpq_pkg::OP_W-1:0]   i_operation,
    input  logic [bpq_pkg::VAL_W-1:0]  i_elem_value,
    input  logic [bpq_pkg::LVL_W-1:0]  i_priority_req,
    output logic                       o_out_valid,
    input  logic                       i_out_ready,
    output logic [bpq_pkg::VAL_W-1:0]  o_head_value,
    output logic [bpq_pkg::LVL_W-1:0]  o_head_priority,
    output logic [bpq_pkg::CNT_W-1:0]  o_entry_count,
    output logic                       o_is_empty,
    output logic [bpq_pkg::ST_W-1:0]   o_status
);
    import bpq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_ENQ  = 7'b0000010,
        S_DQ1  = 7'b0000100,
        S_DQ2  = 7'b0001000,
        S_DQ3  = 7'b0010000,
        S_TOP  = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state             r_state, n_state;
    logic [LEVELS-1:0]  r_map, n_map;
    logic [SLOT_W-1:0]  r_free_head, n_free_head;
    logic [CNT_W-1:0]   r_fresh, n_fresh;
    logic [CNT_W-1:0]   r_count, n_count;
    logic               r_out_valid, n_out_valid;

    logic [VAL_W-1:0]   r_top_val, n_top_val;
    logic [VAL_W-1:0]   r_val, n_val;
    logic [LVL_W-1:0]   r_prio, n_prio;
    logic [LVL_W-1:0]   r_lvl, n_lvl;
    logic [SLOT_W-1:0]  r_slot, n_slot;
    logic [SLOT_W-1:0]  r_tail, n_tail;
    logic [ST_W-1:0]    r_status, n_status;
    logic [VAL_W-1:0]   r_out_value, n_out_value;
    logic [LVL_W-1:0]   r_out_prio, n_out_prio;
    logic [CNT_W-1:0]   r_out_count, n_out_count;
    logic               r_out_empty, n_out_empty;
    logic [ST_W-1:0]    r_out_status, n_out_status;

    // memory ports
    logic               val_we, val_re;
    logic [SLOT_W-1:0]  val_waddr, val_raddr;
    logic [VAL_W-1:0]   val_wdata, val_rdata;
    logic               link_we, link_re;
    logic [SLOT_W-1:0]  link_waddr, link_raddr;
    logic [SLOT_W-1:0]  link_wdata, link_rdata;
    logic               lvl_we, lvl_re;
    logic [LVL_W-1:0]   lvl_waddr, lvl_raddr;
    t_lvl_entry         lvl_wdata, lvl_rdata;

    logic               w_out_free;
    logic               w_accept;
    logic [LVL_W-1:0]   w_lowest;
    logic [LEVELS-1:0]  w_map_clr;
    logic               w_reuse;
    logic [SLOT_W-1:0]  w_new_slot;

    bpq_ram #(.WIDTH(VAL_W), .DEPTH(CAPACITY)) u_val_ram (
        .i_clk   (i_clk),
        .i_we    (val_we),
        .i_waddr (val_waddr),
        .i_wdata (val_wdata),
        .i_re    (val_re),
        .i_raddr (val_raddr),
        .o_rdata (val_rdata)
    );

    bpq_ram #(.WIDTH(SLOT_W), .DEPTH(CAPACITY)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_re    (link_re),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    bpq_ram #(.WIDTH($bits(t_lvl_entry)), .DEPTH(LEVELS)) u_lvl_ram (
        .i_clk   (i_clk),
        .i_we    (lvl_we),
        .i_waddr (lvl_waddr),
        .i_wdata (lvl_wdata),
        .i_re    (lvl_re),
        .i_raddr (lvl_raddr),
        .o_rdata (lvl_rdata)
    );

    assign w_out_free = !r_out_valid || i_out_ready;
    // one transaction in flight: every write lands before the next read is issued
    assign o_in_ready = (r_state == S_IDLE) || ((r_state == S_DONE) && w_out_free);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_lowest   = f_lowest(r_map);
    assign w_map_clr  = r_map & ~(LEVELS'(1) << r_lvl);
    assign w_reuse    = (r_fresh > r_count);
    assign w_new_slot = w_reuse ? r_free_head : r_fresh[SLOT_W-1:0];

    always_comb begin
        n_state      = r_state;
        n_map        = r_map;
        n_free_head  = r_free_head;
        n_fresh      = r_fresh;
        n_count      = r_count;
        n_out_valid  = r_out_valid;
        n_top_val    = r_top_val;
        n_val        = r_val;
        n_prio       = r_prio;
        n_lvl        = r_lvl;
        n_slot       = r_slot;
        n_tail       = r_tail;
        n_status     = r_status;
        n_out_value  = r_out_value;
        n_out_prio   = r_out_prio;
        n_out_count  = r_out_count;
        n_out_empty  = r_out_empty;
        n_out_status = r_out_status;

        val_we     = 1'b0;
        val_waddr  = w_new_slot;
        val_wdata  = r_val;
        val_re     = 1'b0;
        val_raddr  = link_rdata;
        link_we    = 1'b0;
        link_waddr = r_slot;
        link_wdata = r_free_head;
        link_re    = 1'b0;
        link_raddr = r_free_head;
        lvl_we     = 1'b0;
        lvl_waddr  = r_lvl;
        lvl_wdata  = lvl_rdata;
        lvl_re     = 1'b0;
        lvl_raddr  = w_lowest;

        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                n_state = S_IDLE;
            end
            S_ENQ: begin
                val_we     = 1'b1;
                val_waddr  = w_new_slot;
                lvl_we     = 1'b1;
                lvl_waddr  = r_prio;
                if (r_map[r_prio]) begin
                    // append behind the current tail of this level
                    link_we        = 1'b1;
                    link_waddr     = lvl_rdata.tail;
                    link_wdata     = w_new_slot;
                    lvl_wdata.head = lvl_rdata.head;
                end else begin
                    lvl_wdata.head = w_new_slot;
                end
                lvl_wdata.tail = w_new_slot;
                n_map[r_prio]  = 1'b1;
                if (w_reuse) begin
                    n_free_head = link_rdata;
                end else begin
                    n_fresh = r_fresh + CNT_W'(1);
                end
                n_count = r_count + CNT_W'(1);
                if ((r_map == '0) || (r_prio < w_lowest)) begin
                    n_top_val = r_val;
                end
                n_state = S_DONE;
            end
            S_DQ1: begin
                n_slot     = lvl_rdata.head;
                n_tail     = lvl_rdata.tail;
                link_re    = 1'b1;
                link_raddr = lvl_rdata.head;
                n_state    = S_DQ2;
            end
            S_DQ2: begin
                // push the freed slot onto the free list
                link_we     = 1'b1;
                link_waddr  = r_slot;
                link_wdata  = r_free_head;
                n_free_head = r_slot;
                n_count     = r_count - CNT_W'(1);
                if (r_slot == r_tail) begin
                    n_map = w_map_clr;
                    if (w_map_clr == '0) begin
                        n_state = S_DONE;
                    end else begin
                        lvl_re    = 1'b1;
                        lvl_raddr = f_lowest(w_map_clr);
                        n_state   = S_DQ3;
                    end
                end else begin
                    lvl_we         = 1'b1;
                    lvl_waddr      = r_lvl;
                    lvl_wdata.head = link_rdata;
                    lvl_wdata.tail = r_tail;
                    val_re         = 1'b1;
                    val_raddr      = link_rdata;
                    n_state        = S_TOP;
                end
            end
            S_DQ3: begin
                val_re    = 1'b1;
                val_raddr = lvl_rdata.head;
                n_state   = S_TOP;
            end
            S_TOP: begin
                n_top_val = val_rdata;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (w_out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_value  = (r_map != '0) ? r_top_val : '0;
                    n_out_prio   = (r_map != '0) ? w_lowest : '0;
                    n_out_count  = r_count;
                    n_out_empty  = (r_count == '0);
                    n_out_status = r_status;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        if (w_accept) begin
            n_val      = i_elem_value;
            n_prio     = i_priority_req;
            n_lvl      = w_lowest;
            n_status   = ST_OK;
            link_re    = 1'b1;
            link_raddr = r_free_head;
            lvl_re     = 1'b1;
            lvl_raddr  = (i_operation == OP_ENQ) ? i_priority_req : w_lowest;
            if (i_operation == OP_ENQ) begin
                if (i_priority_req > i_max_prio) begin
                    n_status = ST_PRIO;
                    n_state  = S_DONE;
                end else if (r_count >= CNT_W'(CAPACITY)) begin
                    n_status = ST_FULL;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_ENQ;
                end
            end else if (i_operation == OP_DEQ) begin
                if (r_map == '0) begin
                    n_status = ST_EMPTY;
                    n_state  = S_DONE;
                end else begin
                    n_state = S_DQ1;
                end
            end else begin
                n_status = (r_map == '0) ? ST_EMPTY : ST_OK;
                n_state  = S_DONE;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_map       <= '0;
            r_free_head <= '0;
            r_fresh     <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_map       <= n_map;
            r_free_head <= n_free_head;
            r_fresh     <= n_fresh;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top_val    <= n_top_val;
        r_val        <= n_val;
        r_prio       <= n_prio;
        r_lvl        <= n_lvl;
        r_slot       <= n_slot;
        r_tail       <= n_tail;
        r_status     <= n_status;
        r_out_value  <= n_out_value;
        r_out_prio   <= n_out_prio;
        r_out_count  <= n_out_count;
        r_out_empty  <= n_out_empty;
        r_out_status <= n_out_status;
    end

    assign o_out_valid     = r_out_valid;
    assign o_head_value    = r_out_value;
    assign o_head_priority = r_out_prio;
    assign o_entry_count   = r_out_count;
    assign o_is_empty      = r_out_empty;
    assign o_status        = r_out_status;

endmodule

@@ design/bucket_priority_queue_top.sv @@
// Priority queue with one FIFO per level, level 0 served first. Each input
// transaction is an enqueue, a dequeue or a peek, and yields exactly one result
// transaction that reports the head value, head level, entry count, empty flag
// and a status (ok, full, empty, or priority above max_priority_level, which is
// written through the APB port at byte address 0). Values sit in a 256-entry
// value RAM, next pointers and the free list in a link RAM, and per-level head
// and tail pointers in a 16-entry level RAM; all three have a registered read.
// One transaction is handled at a time: a peek or refused request goes straight
// to the result, an enqueue writes first, and a dequeue reads the head's link,
// frees the slot and fetches the new head, but skips the fetch if the queue
// empties and rereads the level RAM if its level empties. The result register
// lets the next transaction be accepted while a result waits. No clearing pass
// runs after reset; the queue is usable on the first cycle out of reset.
module bucket_priority_queue_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [bpq_pkg::CFG_AW-1:0]  paddr,
    input  logic [bpq_pkg::CFG_DW-1:0]  pwdata,
    output logic [bpq_pkg::CFG_DW-1:0]  prdata,
    output logic                        pready,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic [bpq_pkg::OP_W-1:0]    i_operation,
    input  logic [bpq_pkg::VAL_W-1:0]   i_elem_value,
    input  logic [bpq_pkg::LVL_W-1:0]   i_priority_req,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bpq_pkg::VAL_W-1:0]   o_head_value,
    output logic [bpq_pkg::LVL_W-1:0]   o_head_priority,
    output logic [bpq_pkg::CNT_W-1:0]   o_entry_count,
    output logic                        o_is_empty,
    output logic [bpq_pkg::ST_W-1:0]    o_status
);
    import bpq_pkg::*;

    logic [LVL_W-1:0] max_prio;

    bpq_cfg u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready),
        .o_max_prio (max_prio)
    );

    bpq_core u_core (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_max_prio      (max_prio),
        .i_in_valid      (i_in_valid),
        .o_in_ready      (o_in_ready),
        .i_operation     (i_operation),
        .i_elem_value    (i_elem_value),
        .i_priority_req  (i_priority_req),
        .o_out_valid     (o_out_valid),
        .i_out_ready     (i_out_ready),
        .o_head_value    (o_head_value),
        .o_head_priority (o_head_priority),
        .o_entry_count   (o_entry_count),
        .o_is_empty      (o_is_empty),
        .o_status        (o_status)
    );

    a_empty_matches_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_is_empty == (o_entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_empty_head_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_is_empty) |-> ((o_head_value == '0) && (o_head_priority == '0)))
        else $error("head fields not zero on empty queue");

    a_full_at_capacity: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_FULL)) |-> (o_entry_count == CNT_W'(CAPACITY)))
        else $error("full refusal below capacity");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_entry_count <= CNT_W'(CAPACITY)))
        else $error("entry count above capacity");

endmodule
